[rtl/slfr_pkg.sv]
package slfr_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'h94;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'hC3;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_payload;
    } t_cfg;

endpackage

[rtl/slfr_stream_if.sv]
interface slfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] frame_length;

    modport source (
        output valid, output payload_byte, output first_byte,
        output last_byte, output frame_length, input ready
    );
    modport sink (
        input valid, input payload_byte, input first_byte,
        input last_byte, input frame_length, output ready
    );
endinterface

[rtl/slfr_regs.sv]
module slfr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slfr_pkg::ADDR_W-1:0] paddr,
    input  logic [slfr_pkg::DATA_W-1:0] pwdata,
    output logic [slfr_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output slfr_pkg::t_cfg              o_cfg
);
    import slfr_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] w_index;
    logic       w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                REG_SYNC_FIRST:  n_cfg.sync_first  = pwdata[7:0];
                REG_SYNC_SECOND: n_cfg.sync_second = pwdata[7:0];
                REG_MAX_PAYLOAD: n_cfg.max_payload = pwdata[15:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_SYNC_FIRST:  prdata = {24'd0, r_cfg.sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_cfg.sync_second};
            REG_MAX_PAYLOAD: prdata = {16'd0, r_cfg.max_payload};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.max_payload <= MAX_PAYLOAD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/sync_length_frame_receiver.sv]
// Length-prefixed frame extractor for a byte stream. It hunts for the two
// sync bytes, reads a big-endian 16-bit length, and forwards each payload
// byte as one result request carrying first/last marks and the frame length.
// Frames whose length is zero or above max_payload are dropped silently.
// The header parser and counter update sit in front of a single output
// register, so a byte is accepted each cycle while that register is empty
// or is being taken in the same cycle. While a result waits with the output
// side stalled, input stalls as well, header bytes included.
// Registers (APB): 0x0 sync_first, 0x4 sync_second, 0x8 max_payload.
module sync_length_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    slfr_in_if.sink                     i_rx,
    slfr_out_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slfr_pkg::ADDR_W-1:0] paddr,
    input  logic [slfr_pkg::DATA_W-1:0] pwdata,
    output logic [slfr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import slfr_pkg::*;

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_LEN_HI  = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    t_cfg w_cfg;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_first, n_out_first;
    logic        r_out_last, n_out_last;
    logic [15:0] r_out_len, n_out_len;

    logic        w_accept;
    logic        w_emit;
    logic [15:0] w_full_len;
    logic [16:0] w_next_count;
    logic        w_last;

    slfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_rx.valid && i_rx.ready;

    assign w_full_len   = {r_length[15:8], i_rx.rx_byte};
    assign w_next_count = {1'b0, r_count} + 17'd1;
    assign w_last       = w_next_count >= {1'b0, r_length};

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_count  = r_count;
        w_emit   = 1'b0;
        if (w_accept) begin
            case (r_phase)
                PH_HUNT2: begin
                    n_phase = (i_rx.rx_byte == w_cfg.sync_second) ? PH_LEN_HI : PH_HUNT1;
                end
                PH_LEN_HI: begin
                    n_length = {i_rx.rx_byte, 8'd0};
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = w_full_len;
                    if (w_full_len == 16'd0 || w_full_len > w_cfg.max_payload) begin
                        n_phase = PH_HUNT1;
                    end else begin
                        n_count = 16'd0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    w_emit  = 1'b1;
                    n_count = w_next_count[15:0];
                    if (w_last) begin
                        n_phase = PH_HUNT1;
                    end
                end
                default: begin
                    // unused codes behave as the first-sync hunt
                    n_phase = (i_rx.rx_byte == w_cfg.sync_first) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_byte  = r_out_byte;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;
        n_out_len   = r_out_len;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = i_rx.rx_byte;
            n_out_first = (r_count == 16'd0);
            n_out_last  = w_last;
            n_out_len   = r_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT1;
            r_length    <= 16'd0;
            r_count     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_length    <= n_length;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
        r_out_len   <= n_out_len;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.first_byte   = r_out_first;
    assign o_res.last_byte    = r_out_last;
    assign o_res.frame_length = r_out_len;

endmodule
